// File: rtl/hcrgb_pkg.sv
// Shared constants and types for the hue-cycling HSV-to-RGB color source.
// No dependencies; used by hue_cycle_hsv_to_rgb_core.
package hcrgb_pkg;

  localparam int HUE_BITS_DEF     = 16;
  localparam int CHANNEL_BITS_DEF = 8;

  // elapsed time and hue rate are fixed 16-bit fields
  localparam int TIME_BITS = 16;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;

  localparam logic [TIME_BITS-1:0] HUE_RATE_RST = 16'd6554;
  localparam logic [7:0]           LEVEL_RST    = 8'd255;

  typedef enum logic [IDX_BITS-1:0] {
    REG_HUE_RATE    = 2'd0,
    REG_SATURATION  = 2'd1,
    REG_VALUE_LEVEL = 2'd2
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADV   = 6'b000010,
    S_PHASE = 6'b000100,
    S_CDIV  = 6'b001000,
    S_XMUL  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

// File: rtl/hue_cycle_hsv_to_rgb_core.sv
// Hue-cycling color source: advances a hue phase by elapsed time and converts it
// to RGB through a bit-serial HSV datapath. Depends on hcrgb_pkg.
// Each input passes through S_ADV (serial time*rate and saturation*value multiplies),
// S_PHASE (hue phase update), S_CDIV (restoring divide for chroma), S_XMUL (serial
// chroma*fraction multiply) and S_OUT. in_ready is high only in S_IDLE, so no new input
// is accepted until the previous result has left S_OUT. Synchronous reset
// clears hue phase to zero and loads register defaults (rate 6554, sat/value full).
module hue_cycle_hsv_to_rgb_core
  import hcrgb_pkg::*;
#(
  parameter int HUE_BITS     = HUE_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_BITS-1:0]    elapsed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue,
  output logic [HUE_BITS-1:0]     hue_now,
  input  logic                    cfg_we,
  input  logic [IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HB    = HUE_BITS;
  localparam int PW    = 2 * TIME_BITS;
  localparam int XW    = CB + HB;
  localparam int MAXN  = (HB > TIME_BITS) ? HB : TIME_BITS;
  localparam int CNT_W = $clog2(MAXN);
  localparam logic [CB:0] CMAX = {1'b0, {CB{1'b1}}};

  state_t state;
  logic [CNT_W-1:0] cnt;

  logic [TIME_BITS-1:0] hue_rate;
  logic [CB-1:0]        saturation;
  logic [CB-1:0]        value_level;
  logic [HB-1:0]        hue_phase;

  logic [TIME_BITS-1:0] el_sh;
  logic [PW-1:0]        adv_acc;
  logic [CB-1:0]        sat_sh;
  logic [2*CB-1:0]      cv_acc;
  logic [CB-1:0]        rem;
  logic [CB-1:0]        c_q;
  logic [2:0]           sector;
  logic [HB-1:0]        t_sh;
  logic [XW-1:0]        x_acc;

  logic [CB:0]   trial;
  logic          q_bit;
  logic [HB+2:0] h6;
  logic [CB-1:0] x_val;
  logic [CB-1:0] m_val;
  logic [CB-1:0] r_next;
  logic [CB-1:0] g_next;
  logic [CB-1:0] b_next;

  assign in_ready = (state == S_IDLE);

  assign trial = {rem, cv_acc[CB-1]};
  assign q_bit = (trial >= CMAX);
  assign h6    = ({3'b000, hue_phase} << 2) + ({3'b000, hue_phase} << 1);
  assign x_val = x_acc[XW-1:HB];
  assign m_val = value_level - c_q;

  always_comb begin
    r_next = m_val;
    g_next = m_val;
    b_next = m_val;
    case (sector)
      3'd0: begin
        r_next = c_q + m_val;
        g_next = x_val + m_val;
      end
      3'd1: begin
        r_next = x_val + m_val;
        g_next = c_q + m_val;
      end
      3'd2: begin
        g_next = c_q + m_val;
        b_next = x_val + m_val;
      end
      3'd3: begin
        g_next = x_val + m_val;
        b_next = c_q + m_val;
      end
      3'd4: begin
        r_next = x_val + m_val;
        b_next = c_q + m_val;
      end
      default: begin
        r_next = c_q + m_val;
        b_next = x_val + m_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_rate    <= HUE_RATE_RST;
      saturation  <= CB'(LEVEL_RST);
      value_level <= CB'(LEVEL_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_RATE:    hue_rate    <= cfg_data;
        REG_SATURATION:  saturation  <= cfg_data[CB-1:0];
        REG_VALUE_LEVEL: value_level <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      hue_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ADV;
            cnt   <= '0;
          end
        end
        S_ADV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(TIME_BITS - 1)) begin
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          hue_phase <= hue_phase + adv_acc[PW-1 -: HB];
          state     <= S_CDIV;
          cnt       <= '0;
        end
        S_CDIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CB - 1)) begin
            state <= S_XMUL;
            cnt   <= '0;
          end
        end
        S_XMUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(HB - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        el_sh   <= elapsed;
        sat_sh  <= saturation;
        adv_acc <= '0;
        cv_acc  <= '0;
      end
      S_ADV: begin
        el_sh   <= el_sh << 1;
        adv_acc <= (adv_acc << 1) + (el_sh[TIME_BITS-1] ? PW'(hue_rate) : '0);
        if (cnt < CNT_W'(CB)) begin
          sat_sh <= sat_sh << 1;
          cv_acc <= (cv_acc << 1) + (sat_sh[CB-1] ? (2*CB)'(value_level) : '0);
        end
      end
      S_PHASE: begin
        rem <= cv_acc[2*CB-1:CB];
      end
      S_CDIV: begin
        cv_acc <= cv_acc << 1;
        rem    <= q_bit ? CB'(trial - CMAX) : trial[CB-1:0];
        c_q    <= {c_q[CB-2:0], q_bit};
        sector <= h6[HB+2:HB];
        t_sh   <= h6[HB-1:0] ^ {HB{h6[HB]}};
        x_acc  <= '0;
      end
      S_XMUL: begin
        t_sh  <= t_sh << 1;
        x_acc <= (x_acc << 1) + (t_sh[HB-1] ? XW'(c_q) : '0);
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          red     <= r_next;
          green   <= g_next;
          blue    <= b_next;
          hue_now <= hue_phase;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb_hue_cycle_hsv_to_rgb_core.sv
// Testbench for hue_cycle_hsv_to_rgb_core: drives elapsed-time ticks, predicts hue phase
// and RGB in-line, and checks every output transfer in order. Depends on hcrgb_pkg.
`timescale 1ns / 1ps

module tb_hue_cycle_hsv_to_rgb_core;
  import hcrgb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 60;
  localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [15:0] CHAN_MAX = 16'd255;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
  } color_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [TIME_BITS-1:0] elapsed;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic [15:0]         hue_now;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  // predictor state
  logic [15:0] hue_phase_q;
  logic [15:0] hue_rate_q;
  logic [7:0]  sat_q;
  logic [7:0]  val_q;
  color_t      predicted_colors[$];

  int  errors;
  int  stall_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  hold_reqs;
  int  hold_seen;
  int  hold_left;
  int  sink_gap;

  hue_cycle_hsv_to_rgb_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .elapsed   (elapsed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hue_now   (hue_now),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic color_t advance_hue(input logic [15:0] dt);
    logic [31:0] step_prod;
    logic [18:0] h6;
    logic [15:0] frac;
    logic [15:0] t;
    logic [15:0] sv;
    logic [23:0] ct;
    logic [7:0]  c, x, m, r, g, b;
    sector_t     sec;
    color_t      col;
    step_prod   = dt * hue_rate_q;
    hue_phase_q = hue_phase_q + step_prod[31:16];
    h6   = hue_phase_q * 19'd6;
    sec  = sector_t'(h6[18:16]);
    frac = h6[15:0];
    sv   = sat_q * val_q;
    c    = 8'(sv / CHAN_MAX);
    t    = h6[16] ? 16'hFFFF - frac : frac;
    ct   = c * t;
    x    = ct[23:16];
    m    = val_q - c;
    case (sec)
      SEC_RED: begin
        r = c; g = x; b = 8'd0;
      end
      SEC_YELLOW: begin
        r = x; g = c; b = 8'd0;
      end
      SEC_GREEN: begin
        r = 8'd0; g = c; b = x;
      end
      SEC_CYAN: begin
        r = 8'd0; g = x; b = c;
      end
      SEC_BLUE: begin
        r = x; g = 8'd0; b = c;
      end
      default: begin
        r = c; g = 8'd0; b = x;
      end
    endcase
    col.red   = r + m;
    col.green = g + m;
    col.blue  = b + m;
    col.hue   = hue_phase_q;
    return col;
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // output side: random ready bursts plus an on-request long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap  <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
      sink_gap  <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    color_t exp_col;
    if (!rst && out_valid && out_ready) begin
      if (predicted_colors.size() == 0) begin
        $error("output transfer with no prediction pending");
        errors++;
      end else begin
        exp_col = predicted_colors.pop_front();
        if (red !== exp_col.red) begin
          $error("red: expected %0d, got %0d", exp_col.red, red);
          errors++;
        end
        if (green !== exp_col.green) begin
          $error("green: expected %0d, got %0d", exp_col.green, green);
          errors++;
        end
        if (blue !== exp_col.blue) begin
          $error("blue: expected %0d, got %0d", exp_col.blue, blue);
          errors++;
        end
        if (hue_now !== exp_col.hue) begin
          $error("hue_now: expected %0d, got %0d", exp_col.hue, hue_now);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [15:0] dt);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    elapsed  <= dt;
    do @(posedge clk); while (!in_ready);
    predicted_colors.push_back(advance_hue(dt));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_colors.size() != 0);
  endtask

  // leaves cfg_we high; caller lowers it after the last write
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_HUE_RATE:    hue_rate_q = data;
      REG_SATURATION:  sat_q      = data[7:0];
      REG_VALUE_LEVEL: val_q      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] rate, input logic [15:0] sat,
                            input logic [15:0] val);
    drain();
    write_reg(REG_HUE_RATE, rate);
    write_reg(REG_SATURATION, sat);
    write_reg(REG_VALUE_LEVEL, val);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'd0);
  endtask

  task automatic test_phase_wrap();
    set_config(16'd32768, 16'd255, 16'd255);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'd4);
    send_tick(16'd0);
  endtask

  task automatic test_sector_walk();
    set_config(16'hFFFF, 16'd200, 16'd230);
    repeat (7) send_tick(16'd10923);
  endtask

  task automatic test_level_extremes();
    set_config(16'd9000, 16'd0, 16'd255);
    send_tick(16'd20000);
    set_config(16'd9000, 16'd255, 16'd0);
    send_tick(16'd20000);
    set_config(16'd0, 16'd1, 16'd1);
    send_tick(16'hFFFF);
    set_config(16'hFFFF, 16'd255, 16'd128);
    send_tick(16'h8001);
  endtask

  task automatic test_register_masking();
    drain();
    write_reg(REG_SATURATION, 16'hFF80);
    write_reg(REG_VALUE_LEVEL, 16'hAB40);
    cfg_we <= 1'b0;
    send_tick(16'd3000);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;
    send_tick(16'd3000);
    drain();
    write_reg(REG_UNUSED, 16'h0000);
    cfg_we <= 1'b0;
    send_tick(16'd1);
  endtask

  task automatic test_config_sweep();
    logic [15:0] rate, sat, val;
    int n;
    for (int ph = 0; ph < 8; ph++) begin
      rate = 16'($urandom);
      sat  = 16'($urandom);
      val  = 16'($urandom);
      case (ph)
        0: rate = 16'd0;
        1: begin
          rate = 16'hFFFF; sat = 16'hFFFF; val = 16'hFFFF;
        end
        2: sat = 16'd0;
        3: val = 16'd0;
        4: rate = 16'd1;
        default: ;
      endcase
      set_config(rate, sat, val);
      if (ph % 3 == 2) begin
        drain();
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
      end
      n = $urandom_range(150, 200);
      repeat (n) send_tick(pick_elapsed());
    end
  endtask

  task automatic test_output_backpressure();
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    src_idle_en <= 1'b0;
    hold_reqs   <= hold_reqs + 1;
    repeat (16) send_tick(pick_elapsed());
    src_idle_en <= 1'b1;
  endtask

  task automatic test_full_rate();
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    src_idle_en  <= 1'b0;
    sink_idle_en <= 1'b0;
    repeat (250) send_tick(pick_elapsed());
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    elapsed      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_HUE_RATE;
    cfg_data     = '0;
    errors       = 0;
    hue_phase_q  = 16'd0;
    hue_rate_q   = HUE_RATE_RST;
    sat_q        = LEVEL_RST;
    val_q        = LEVEL_RST;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_phase_wrap();
    test_sector_walk();
    test_level_extremes();
    test_register_masking();
    test_config_sweep();
    test_output_backpressure();
    test_full_rate();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
